// ===== rtl/core/sap_pkg.sv =====
// sap_pkg: widths, shape codes and the square-root step for the shape area and perimeter block
// no dependencies
`timescale 1ns / 1ps

package sap_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int SQ_W        = 2 * DIFF_W;
    localparam int CROSS_W     = COORD_WIDTH + DIFF_W;
    localparam int SUM_W       = CROSS_W + 2;
    localparam int ROOT_W      = DIFF_W;
    localparam int REM_W       = ROOT_W + 2;
    localparam int AREA_W      = 33;
    localparam int PERIM_W     = 20;

    // pi in q2.16 and twice pi
    localparam int PI_W        = 18;
    localparam int PI_FRAC     = 16;
    localparam logic [PI_W-1:0] PI_Q   = PI_W'(205887);
    localparam logic [PI_W:0]   PI2_Q  = (PI_W + 1)'(411774);

    localparam int ISQ_STEP    = 4;
    localparam int ISQ_STAGES  = (ROOT_W + ISQ_STEP - 1) / ISQ_STEP;
    localparam int FRONT_STAGES = 3;
    localparam int PIPE_DEPTH  = FRONT_STAGES + ISQ_STAGES;

    localparam logic [1:0] KIND_RECT   = 2'd0;
    localparam logic [1:0] KIND_CIRCLE = 2'd1;
    localparam logic [1:0] KIND_TRI    = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]                    kind;
        logic signed [COORD_WIDTH-1:0] ax;
        logic signed [COORD_WIDTH-1:0] ay;
        logic signed [COORD_WIDTH-1:0] bx;
        logic signed [COORD_WIDTH-1:0] by;
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
    } shape_t;

    typedef struct packed {
        logic [1:0]               kind;
        logic signed [AREA_W-1:0] area;
        logic signed [PERIM_W-1:0] perim;
        logic [2:0][SQ_W-1:0]     sq_len;
    } front_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_acc_t;

    // one restoring step of the digit-by-digit integer square root
    function automatic sq_acc_t isqrt_step(sq_acc_t a, logic [1:0] pair);
        logic [REM_W+1:0] r;
        logic [REM_W+1:0] t;
        sq_acc_t          res;
        r = {a.rem, pair};
        t = {2'b00, a.root, 2'b01};
        if (r >= t)
        begin
            res.rem  = REM_W'(r - t);
            res.root = {a.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            res.rem  = REM_W'(r);
            res.root = {a.root[ROOT_W-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/sap_if.sv =====
// sap_if: valid/ready channels for shape words and result words
// depends on sap_pkg
`timescale 1ns / 1ps

interface sap_in_if import sap_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic [1:0]                    kind;
    logic signed [COORD_WIDTH-1:0] coord_a_x;
    logic signed [COORD_WIDTH-1:0] coord_a_y;
    logic signed [COORD_WIDTH-1:0] coord_b_x;
    logic signed [COORD_WIDTH-1:0] coord_b_y;
    logic signed [COORD_WIDTH-1:0] coord_c_x;
    logic signed [COORD_WIDTH-1:0] coord_c_y;

    modport source (output valid, kind, coord_a_x, coord_a_y, coord_b_x, coord_b_y,
                    coord_c_x, coord_c_y, input ready);
    modport sink   (input valid, kind, coord_a_x, coord_a_y, coord_b_x, coord_b_y,
                    coord_c_x, coord_c_y, output ready);
endinterface

interface sap_out_if import sap_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [AREA_W-1:0]  area_value;
    logic signed [PERIM_W-1:0] perimeter_value;

    modport source (output valid, area_value, perimeter_value, input ready);
    modport sink   (input valid, area_value, perimeter_value, output ready);
endinterface

// ===== rtl/core/shape_area_perimeter.sv =====
// shape_area_perimeter: area and perimeter of a rectangle, circle or triangle per word
// pipeline: three front stages, five square-root stages and the output register
// throughput: one word per cycle; the whole pipeline holds only while a result waits
// reset clears the valid bits only; the datapath holds no state between words
`timescale 1ns / 1ps

module shape_area_perimeter import sap_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    sap_in_if.sink  shape_in,
    sap_out_if.source result_out
);

    logic                      en;
    logic [PIPE_DEPTH-1:0]     vld_reg;
    logic                      out_valid_reg;
    logic signed [AREA_W-1:0]  out_area_reg;
    logic signed [PERIM_W-1:0] out_perim_reg;
    logic [1:0]                out_kind_reg;
    shape_t                    shape;
    front_t                    front;
    logic [2:0][ROOT_W-1:0]    side;

    assign en             = !out_valid_reg || result_out.ready;
    assign shape_in.ready = en;

    assign shape.kind = shape_in.kind;
    assign shape.ax   = shape_in.coord_a_x;
    assign shape.ay   = shape_in.coord_a_y;
    assign shape.bx   = shape_in.coord_b_x;
    assign shape.by   = shape_in.coord_b_y;
    assign shape.cx   = shape_in.coord_c_x;
    assign shape.cy   = shape_in.coord_c_y;

    sap_front u_front
    (
        .clk   (clk),
        .en    (en),
        .shape (shape),
        .front (front)
    );

    for (genvar k = 0; k < 3; k++)
    begin : g_side
        sap_isqrt u_isqrt
        (
            .clk      (clk),
            .en       (en),
            .radicand (front.sq_len[k]),
            .root     (side[k])
        );
    end

    // area, perimeter and kind ride alongside the root lanes
    logic [1:0]                kind_d_reg  [ISQ_STAGES];
    logic signed [AREA_W-1:0]  area_d_reg  [ISQ_STAGES];
    logic signed [PERIM_W-1:0] perim_d_reg [ISQ_STAGES];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind_d_reg[0]  <= front.kind;
            area_d_reg[0]  <= front.area;
            perim_d_reg[0] <= front.perim;
            for (int s = 1; s < ISQ_STAGES; s++)
            begin
                kind_d_reg[s]  <= kind_d_reg[s-1];
                area_d_reg[s]  <= area_d_reg[s-1];
                perim_d_reg[s] <= perim_d_reg[s-1];
            end
        end
    end

    logic signed [PERIM_W-1:0] perim_next;

    always_comb
    begin
        if (kind_d_reg[ISQ_STAGES-1] == KIND_TRI)
        begin
            perim_next = PERIM_W'(side[0]) + PERIM_W'(side[1]) + PERIM_W'(side[2]);
        end
        else
        begin
            perim_next = perim_d_reg[ISQ_STAGES-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[PIPE_DEPTH-2:0], shape_in.valid};
            out_valid_reg <= vld_reg[PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_area_reg  <= area_d_reg[ISQ_STAGES-1];
            out_perim_reg <= perim_next;
            out_kind_reg  <= kind_d_reg[ISQ_STAGES-1];
        end
    end

    assign result_out.valid           = out_valid_reg;
    assign result_out.area_value      = out_area_reg;
    assign result_out.perimeter_value = out_perim_reg;

    // a triangle never gives a negative area or perimeter
    a_tri_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg == KIND_TRI
        |-> !out_area_reg[AREA_W-1] && !out_perim_reg[PERIM_W-1])
        else $error("triangle result has a negative field");

    // a circle area is never negative
    a_circle_area: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg == KIND_CIRCLE |-> !out_area_reg[AREA_W-1])
        else $error("circle area negative");

    // a word leaving the last stage lands in the output register
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[PIPE_DEPTH-1] |=> out_valid_reg)
        else $error("word lost at the output register");

    // with no input the pipeline cannot produce a word
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        en && !vld_reg[PIPE_DEPTH-1] |=> !out_valid_reg)
        else $error("result word appeared from an empty stage");

endmodule

// ===== rtl/core/sap_front.sv =====
// sap_front: three stages of differences, products and sums ahead of the square roots
// depends on sap_pkg
`timescale 1ns / 1ps

module sap_front import sap_pkg::*;
(
    input  logic   clk,
    input  logic   en,
    input  shape_t shape,
    output front_t front
);

    function automatic logic signed [DIFF_W-1:0] sdiff(logic signed [COORD_WIDTH-1:0] a,
                                                      logic signed [COORD_WIDTH-1:0] b);
        return DIFF_W'(a) - DIFF_W'(b);
    endfunction

    function automatic logic [DIFF_W-1:0] adiff(logic signed [COORD_WIDTH-1:0] a,
                                               logic signed [COORD_WIDTH-1:0] b);
        logic signed [DIFF_W-1:0] d;
        d = DIFF_W'(a) - DIFF_W'(b);
        return d[DIFF_W-1] ? -d : d;
    endfunction

    // stage 1: differences and magnitudes
    logic [1:0]                    kind1_reg;
    logic signed [COORD_WIDTH-1:0] ax1_reg, ay1_reg, bx1_reg, cx1_reg;
    logic signed [DIFF_W-1:0]      e_bc_reg, e_ca_reg, e_ab_reg;
    logic [5:0][DIFF_W-1:0]        side_d_reg;
    logic [DIFF_W-1:0]             mag1_reg;
    logic                          neg1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind1_reg <= shape.kind;
            ax1_reg   <= shape.ax;
            ay1_reg   <= shape.ay;
            bx1_reg   <= shape.bx;
            cx1_reg   <= shape.cx;
            e_bc_reg  <= sdiff(shape.by, shape.cy);
            e_ca_reg  <= sdiff(shape.cy, shape.ay);
            e_ab_reg  <= sdiff(shape.ay, shape.by);
            side_d_reg[0] <= adiff(shape.bx, shape.ax);
            side_d_reg[1] <= adiff(shape.by, shape.ay);
            side_d_reg[2] <= adiff(shape.cx, shape.bx);
            side_d_reg[3] <= adiff(shape.cy, shape.by);
            side_d_reg[4] <= adiff(shape.cx, shape.ax);
            side_d_reg[5] <= adiff(shape.cy, shape.ay);
            mag1_reg  <= adiff(shape.ax, '0);
            neg1_reg  <= shape.ax[COORD_WIDTH-1];
        end
    end

    // stage 2: products
    logic [1:0]                      kind2_reg;
    logic                            neg2_reg;
    logic signed [2*COORD_WIDTH-1:0] rarea2_reg;
    logic signed [COORD_WIDTH+1:0]   rperim2_reg;
    logic signed [CROSS_W-1:0]       t0_reg, t1_reg, t2_reg;
    logic [5:0][SQ_W-1:0]            sq_reg;
    logic [SQ_W-1:0]                 mag2_reg;
    logic [PERIM_W-1:0]              cperim2_reg;
    logic [DIFF_W+PI_W:0]            cperim_prod;
    logic signed [COORD_WIDTH:0]     rsum;

    assign cperim_prod = (DIFF_W + PI_W + 1)'(mag1_reg) * (DIFF_W + PI_W + 1)'(PI2_Q);
    assign rsum        = (COORD_WIDTH + 1)'(ax1_reg) + (COORD_WIDTH + 1)'(ay1_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind2_reg   <= kind1_reg;
            neg2_reg    <= neg1_reg;
            rarea2_reg  <= (2*COORD_WIDTH)'(ax1_reg) * (2*COORD_WIDTH)'(ay1_reg);
            rperim2_reg <= {rsum, 1'b0};
            t0_reg      <= CROSS_W'(ax1_reg) * CROSS_W'(e_bc_reg);
            t1_reg      <= CROSS_W'(bx1_reg) * CROSS_W'(e_ca_reg);
            t2_reg      <= CROSS_W'(cx1_reg) * CROSS_W'(e_ab_reg);
            for (int k = 0; k < 6; k++)
            begin
                sq_reg[k] <= SQ_W'(side_d_reg[k]) * SQ_W'(side_d_reg[k]);
            end
            mag2_reg    <= SQ_W'(mag1_reg) * SQ_W'(mag1_reg);
            cperim2_reg <= cperim_prod[PI_FRAC +: PERIM_W];
        end
    end

    // stage 3: sums, circle area and selection by kind
    logic [SQ_W+PI_W-1:0]     carea_prod;
    logic signed [SUM_W-1:0]  cross_sum;
    logic [SUM_W-1:0]         cross_abs;
    logic signed [AREA_W-1:0] area_c;
    logic signed [PERIM_W-1:0] perim_c;
    front_t                   front_reg;

    assign carea_prod = (SQ_W + PI_W)'(mag2_reg) * (SQ_W + PI_W)'(PI_Q);
    assign cross_sum  = SUM_W'(t0_reg) + SUM_W'(t1_reg) + SUM_W'(t2_reg);
    assign cross_abs  = cross_sum[SUM_W-1] ? -cross_sum : cross_sum;

    always_comb
    begin
        case (kind2_reg)
            KIND_RECT:
            begin
                area_c  = AREA_W'(rarea2_reg);
                perim_c = PERIM_W'(rperim2_reg);
            end
            KIND_CIRCLE:
            begin
                area_c  = carea_prod[PI_FRAC +: AREA_W];
                perim_c = neg2_reg ? -cperim2_reg : cperim2_reg;
            end
            KIND_TRI:
            begin
                // half the magnitude of the cross sum
                area_c  = cross_abs[AREA_W:1];
                perim_c = '0;
            end
            default:
            begin
                area_c  = '0;
                perim_c = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            front_reg.kind  <= kind2_reg;
            front_reg.area  <= area_c;
            front_reg.perim <= perim_c;
            for (int k = 0; k < 3; k++)
            begin
                front_reg.sq_len[k] <= sq_reg[2*k] + sq_reg[2*k+1];
            end
        end
    end

    assign front = front_reg;

endmodule

// ===== rtl/core/sap_isqrt.sv =====
// sap_isqrt: pipelined truncated integer square root, up to four result bits per stage
// depends on sap_pkg
`timescale 1ns / 1ps

module sap_isqrt import sap_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [SQ_W-1:0]   radicand,
    output logic [ROOT_W-1:0] root
);

    sq_acc_t         acc_reg [ISQ_STAGES];
    logic [SQ_W-1:0] rad_reg [ISQ_STAGES];

    for (genvar s = 0; s < ISQ_STAGES; s++)
    begin : g_stage
        sq_acc_t         acc_in, acc_c;
        logic [SQ_W-1:0] rad_in, rad_c;

        if (s == 0)
        begin : g_first
            assign acc_in = '0;
            assign rad_in = radicand;
        end
        else
        begin : g_next
            assign acc_in = acc_reg[s-1];
            assign rad_in = rad_reg[s-1];
        end

        always_comb
        begin
            acc_c = acc_in;
            rad_c = rad_in;
            for (int j = 0; j < ISQ_STEP; j++)
            begin
                if (s * ISQ_STEP + j < ROOT_W)
                begin
                    acc_c = isqrt_step(acc_c, rad_c[SQ_W-1 -: 2]);
                    rad_c = {rad_c[SQ_W-3:0], 2'b00};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[s] <= acc_c;
                rad_reg[s] <= rad_c;
            end
        end
    end

    assign root = acc_reg[ISQ_STAGES-1].root;

endmodule
